// File: rtl/bbs_pkg.sv
// ----------------------------------------------------------------------------
// bbs_pkg: shared definitions for the 3x3 box blur stream
// Pixel and size widths, line store geometry and the reciprocal used for the
// divide by nine.
// ----------------------------------------------------------------------------
package bbs_pkg;

   // Largest supported image side; sets the line store depth
   localparam int MAX_SIZE = 1024;
   localparam int SIZE_MIN = 3;

   // Field widths
   localparam int PIX_W  = 8;
   localparam int CSR_W  = 11;
   localparam int ADDR_W = $clog2(MAX_SIZE);
   // Effective side length, holds MAX_SIZE itself
   localparam int EFF_W  = ADDR_W + 1;
   // Common width for clamping the written size
   localparam int CMP_W  = (EFF_W > CSR_W) ? EFF_W : CSR_W;

   // One line store entry keeps the upper and middle row pixels of a column
   localparam int LINE_W = 2 * PIX_W;

   // Sum of nine pixels
   localparam int SUM_W = PIX_W + 4;

   // floor(sum / 9) == (sum * RECIP_9) >> RECIP_SHIFT for all sums in range
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP_W     = 13;
   localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(((1 << RECIP_SHIFT) + 8) / 9);
   localparam int PROD_W = SUM_W + RECIP_W;

   // Line store write port
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [LINE_W-1:0] data;
   } bbs_line_wr_type;

endpackage

// File: rtl/bbs_req_if.sv
// ----------------------------------------------------------------------------
// bbs_req_if: pixel input channel
// Valid/ready handshake carrying one grey pixel per transaction.
// ----------------------------------------------------------------------------
interface bbs_req_if
   import bbs_pkg::*;
();

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink   (input valid, input pixel_in, output ready);

endinterface

// File: rtl/bbs_rsp_if.sv
// ----------------------------------------------------------------------------
// bbs_rsp_if: filtered pixel output channel
// Valid/ready handshake carrying one mean value with row and frame marks.
// ----------------------------------------------------------------------------
interface bbs_rsp_if
   import bbs_pkg::*;
();

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_out;
   logic             row_end;
   logic             frame_end;

   modport source (output valid, output pixel_out, output row_end, output frame_end,
                   input ready);
   modport sink   (input valid, input pixel_out, input row_end, input frame_end,
                   output ready);

endinterface

// File: rtl/bbs_line_mem.sv
// ----------------------------------------------------------------------------
// bbs_line_mem: line store for the two previous image rows
// One write port and one read port, registered read data that holds while
// no read is issued.
// ----------------------------------------------------------------------------
module bbs_line_mem
   import bbs_pkg::*;
(
   input  logic              clock,
   input  bbs_line_wr_type   wr,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [LINE_W-1:0] rd_data
);

   logic [LINE_W-1:0] mem [MAX_SIZE];
   logic [LINE_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/box_blur_3x3_stream.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_stream: streaming 3x3 box filter over a square grey image
// Takes pixels in raster order and returns the truncated mean of every
// interior 3x3 neighbourhood, marking row and frame ends.
// ----------------------------------------------------------------------------
// Usage
//   req_chan carries one 8-bit pixel per transaction in raster order. A frame
//   starts after reset, after the last pixel of the previous frame, or after
//   a write of csr_wr_data with csr_wr_en (side length, clamped to 3..1024).
//   Write the size only while the block is idle.
//   rsp_chan carries one result per interior pixel: the pixel one row up and
//   one column left of the pixel just taken. Border positions give nothing.
//   row_end marks the last result of an output row, frame_end the last one
//   of the frame.
//   Throughput is one pixel per clock while rsp_chan is not stalled: the
//   line store is read at the incoming column and written back as the pixel
//   leaves stage 1, and a column is only revisited a full row later. Stage 1
//   holds the memory read, stage 2 the adder tree sum and the output
//   register the divide by nine through a reciprocal multiply.
//   Each pipeline stage holds its own valid bit, so input keeps flowing into
//   empty stages while a result waits on a stalled receiver.
//   Reset clears the counters, window and pipeline and sets the size to
//   1024; the line store needs no clearing.
// ----------------------------------------------------------------------------
module box_blur_3x3_stream
   import bbs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [CSR_W-1:0] csr_wr_data,
   bbs_req_if.sink          req_chan,
   bbs_rsp_if.source        rsp_chan
);

   // Frame position and size
   logic [EFF_W-1:0]  size_ff,  size_in;
   logic [ADDR_W-1:0] col_ff,   col_in;
   logic [ADDR_W-1:0] row_ff,   row_in;

   // Stage 1: waiting for line store data
   logic              s1_v_ff,     s1_v_in;
   logic [PIX_W-1:0]  s1_pix_ff,   s1_pix_in;
   logic [ADDR_W-1:0] s1_addr_ff,  s1_addr_in;
   logic              s1_res_ff,   s1_res_in;
   logic              s1_row_ff,   s1_row_in;
   logic              s1_frame_ff, s1_frame_in;

   // Window: [0..2] column c-1, [3..5] column c-2 (upper, middle, current)
   logic [PIX_W-1:0]  win_ff [6];
   logic [PIX_W-1:0]  win_in [6];

   // Stage 2: neighbourhood sum
   logic              s2_v_ff,     s2_v_in;
   logic [SUM_W-1:0]  s2_sum_ff,   s2_sum_in;
   logic              s2_row_ff,   s2_row_in;
   logic              s2_frame_ff, s2_frame_in;

   // Output register
   logic              out_v_ff,     out_v_in;
   logic [PIX_W-1:0]  out_pix_ff,   out_pix_in;
   logic              out_row_ff,   out_row_in;
   logic              out_frame_ff, out_frame_in;

   logic              accept;
   logic              out_free, s2_free, s1_done, s1_free;
   logic              last_col, last_row;
   logic [CMP_W-1:0]  csr_size;
   logic [LINE_W-1:0] rd_data;
   logic [PIX_W-1:0]  up_pix, mid_pix;
   logic [SUM_W-1:0]  sum;
   logic [PROD_W-1:0] prod;
   bbs_line_wr_type   line_wr;

   // Stage flow control
   assign out_free = !out_v_ff || rsp_chan.ready;
   assign s2_free  = !s2_v_ff || out_free;
   assign s1_done  = s1_v_ff && (!s1_res_ff || s2_free);
   assign s1_free  = !s1_v_ff || s1_done;
   assign req_chan.ready = s1_free;
   assign accept   = req_chan.valid && s1_free;

   // Position of the incoming pixel
   assign last_col = (EFF_W'(col_ff) + EFF_W'(1)) >= size_ff;
   assign last_row = (EFF_W'(row_ff) + EFF_W'(1)) >= size_ff;
   assign csr_size = CMP_W'(csr_wr_data);

   // Size register and frame counters
   always_comb begin
      size_in = size_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      if (csr_wr_en) begin
         if (csr_size < CMP_W'(SIZE_MIN)) begin
            size_in = EFF_W'(SIZE_MIN);
         end else if (csr_size > CMP_W'(MAX_SIZE)) begin
            size_in = EFF_W'(MAX_SIZE);
         end else begin
            size_in = EFF_W'(csr_size);
         end
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ADDR_W'(1);
         end else begin
            col_in = col_ff + ADDR_W'(1);
         end
      end
   end

   // Stage 1 load
   always_comb begin
      s1_v_in     = s1_v_ff;
      s1_pix_in   = s1_pix_ff;
      s1_addr_in  = s1_addr_ff;
      s1_res_in   = s1_res_ff;
      s1_row_in   = s1_row_ff;
      s1_frame_in = s1_frame_ff;
      if (s1_free) begin
         s1_v_in     = accept;
         s1_pix_in   = req_chan.pixel_in;
         s1_addr_in  = col_ff;
         s1_res_in   = (row_ff >= ADDR_W'(2)) && (col_ff >= ADDR_W'(2));
         s1_row_in   = last_col;
         s1_frame_in = last_col && last_row;
      end
   end

   // Line store: read at the incoming column, write back when stage 1 retires
   assign up_pix  = rd_data[LINE_W-1:PIX_W];
   assign mid_pix = rd_data[PIX_W-1:0];

   assign line_wr.en   = s1_done;
   assign line_wr.addr = s1_addr_ff;
   assign line_wr.data = {mid_pix, s1_pix_ff};

   bbs_line_mem u_line_mem (
      .clock   (clock),
      .wr      (line_wr),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (rd_data)
   );

   // Neighbourhood sum
   always_comb begin
      sum = SUM_W'(up_pix) + SUM_W'(mid_pix) + SUM_W'(s1_pix_ff);
      for (int k = 0; k < 6; k++) begin
         sum = sum + SUM_W'(win_ff[k]);
      end
   end

   // Window shift
   always_comb begin
      for (int k = 0; k < 6; k++) begin
         win_in[k] = win_ff[k];
      end
      if (s1_done) begin
         win_in[3] = win_ff[0];
         win_in[4] = win_ff[1];
         win_in[5] = win_ff[2];
         win_in[0] = up_pix;
         win_in[1] = mid_pix;
         win_in[2] = s1_pix_ff;
      end
   end

   // Stage 2 load
   always_comb begin
      s2_v_in     = s2_v_ff;
      s2_sum_in   = s2_sum_ff;
      s2_row_in   = s2_row_ff;
      s2_frame_in = s2_frame_ff;
      if (s2_free) begin
         s2_v_in     = s1_done && s1_res_ff;
         s2_sum_in   = sum;
         s2_row_in   = s1_row_ff;
         s2_frame_in = s1_frame_ff;
      end
   end

   // Divide by nine through the reciprocal
   assign prod = PROD_W'(s2_sum_ff) * PROD_W'(RECIP_9);

   always_comb begin
      out_v_in     = out_v_ff;
      out_pix_in   = out_pix_ff;
      out_row_in   = out_row_ff;
      out_frame_in = out_frame_ff;
      if (out_free) begin
         out_v_in     = s2_v_ff;
         out_pix_in   = prod[RECIP_SHIFT +: PIX_W];
         out_row_in   = s2_row_ff;
         out_frame_in = s2_frame_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= EFF_W'(MAX_SIZE);
         col_ff   <= '0;
         row_ff   <= '0;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         for (int k = 0; k < 6; k++) begin
            win_ff[k] <= '0;
         end
      end else begin
         size_ff  <= size_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s2_v_in;
         out_v_ff <= out_v_in;
         for (int k = 0; k < 6; k++) begin
            win_ff[k] <= win_in[k];
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_pix_ff    <= s1_pix_in;
      s1_addr_ff   <= s1_addr_in;
      s1_res_ff    <= s1_res_in;
      s1_row_ff    <= s1_row_in;
      s1_frame_ff  <= s1_frame_in;
      s2_sum_ff    <= s2_sum_in;
      s2_row_ff    <= s2_row_in;
      s2_frame_ff  <= s2_frame_in;
      out_pix_ff   <= out_pix_in;
      out_row_ff   <= out_row_in;
      out_frame_ff <= out_frame_in;
   end

   assign rsp_chan.valid     = out_v_ff;
   assign rsp_chan.pixel_out = out_pix_ff;
   assign rsp_chan.row_end   = out_row_ff;
   assign rsp_chan.frame_end = out_frame_ff;

   // Checks
   a_col_in_frame: assert property (@(posedge clock) disable iff (reset)
      EFF_W'(col_ff) < size_ff)
      else $error("column counter beyond image side");

   a_size_range: assert property (@(posedge clock) disable iff (reset)
      size_ff >= EFF_W'(SIZE_MIN) && size_ff <= EFF_W'(MAX_SIZE))
      else $error("effective size out of range");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      accept && line_wr.en |-> col_ff != line_wr.addr)
      else $error("line store read and write hit the same column");

   a_frame_on_row: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_frame_ff |-> out_row_ff)
      else $error("frame end without row end");

   a_s2_held: assert property (@(posedge clock) disable iff (reset)
      s2_v_ff && !out_free |=> s2_v_ff && $stable(s2_sum_ff))
      else $error("sum stage lost its value while output stalled");

endmodule

// File: tb/tb_box_blur_3x3_stream.sv
// ----------------------------------------------------------------------------
// tb_box_blur_3x3_stream: self-checking bench for the 3x3 box blur stream
// Drives pixel streams at several side lengths (clamped, extreme and small)
// and checks every filtered pixel and its row and frame marks against a
// behavioural line store and window model, under varying sender and
// receiver back-pressure.
// ----------------------------------------------------------------------------
module tb_box_blur_3x3_stream;
   import bbs_pkg::*;

   // Cycles with no transaction on either channel before the run is abandoned
   localparam int unsigned STUCK_LIMIT   = 2000;
   // Pause after the last expected result; covers the three-stage pipeline
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned IDLE_HEAVY    = 73;
   localparam int unsigned IDLE_BOTH     = 36;
   localparam int unsigned RANDOM_PHASES = 16;
   localparam int unsigned PRINT_CAP     = 100;

   typedef struct packed {
      logic [PIX_W-1:0] mean;
      logic             row_end;
      logic             frame_end;
   } blur_result_type;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             csr_wr_en   = 1'b0;
   logic [CSR_W-1:0] csr_wr_data = '0;

   bbs_req_if req_chan ();
   bbs_rsp_if rsp_chan ();

   box_blur_3x3_stream i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   // Clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Pixels waiting to be sent and means waiting to be received
   logic [PIX_W-1:0] pixel_backlog[$];
   blur_result_type  pending_means[$];

   // Shadow of the block state
   logic [PIX_W-1:0] upper_line[MAX_SIZE];
   logic [PIX_W-1:0] middle_line[MAX_SIZE];
   logic [PIX_W-1:0] window_pix[6];
   logic [CSR_W-1:0] side_reg = CSR_W'(MAX_SIZE);
   int unsigned      col_pos  = 0;
   int unsigned      row_pos  = 0;

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   int unsigned error_count   = 0;
   int unsigned stuck_cycles  = 0;
   blur_result_type got_mean;

   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_CAP)
         $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   // Advance the shadow state by one pixel; queue the mean it completes
   function automatic void blur_take_pixel(input logic [PIX_W-1:0] pix);
      int unsigned      side;
      int unsigned      sum;
      logic [PIX_W-1:0] up;
      logic [PIX_W-1:0] mid;
      blur_result_type  res;
      side = side_reg;
      if (side < SIZE_MIN)
         side = SIZE_MIN;
      if (side > MAX_SIZE)
         side = MAX_SIZE;
      up  = upper_line[col_pos];
      mid = middle_line[col_pos];
      // interior position one row up, one column left
      if (row_pos >= 2 && col_pos >= 2) begin
         sum = up + mid + pix;
         for (int k = 0; k < 6; k++)
            sum += window_pix[k];
         res.mean      = PIX_W'(sum / 9);
         res.row_end   = (col_pos + 1 >= side);
         res.frame_end = (col_pos + 1 >= side) && (row_pos + 1 >= side);
         pending_means.push_back(res);
      end
      upper_line[col_pos]  = mid;
      middle_line[col_pos] = pix;
      window_pix[3] = window_pix[0];
      window_pix[4] = window_pix[1];
      window_pix[5] = window_pix[2];
      window_pix[0] = up;
      window_pix[1] = mid;
      window_pix[2] = pix;
      if (col_pos + 1 >= side) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= side) ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
   endfunction

   // Driver: presents backlog pixels, idling at random
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid    <= 1'b0;
         req_chan.pixel_in <= '0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            blur_take_pixel(req_chan.pixel_in);
         if (!req_chan.valid || req_chan.ready) begin
            if (pixel_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_chan.valid    <= 1'b1;
               req_chan.pixel_in <= pixel_backlog.pop_front();
            end else begin
               req_chan.valid    <= 1'b0;
               req_chan.pixel_in <= PIX_W'($urandom);
            end
         end
      end
   end

   // Monitor: checks each result transaction, stalls at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_means.size() == 0) begin
               report_mismatch($sformatf("unexpected result, mean %0d", rsp_chan.pixel_out));
            end else begin
               got_mean = pending_means.pop_front();
               if (rsp_chan.pixel_out !== got_mean.mean)
                  report_mismatch($sformatf("mean %0d, want %0d",
                                            rsp_chan.pixel_out, got_mean.mean));
               if (rsp_chan.row_end !== got_mean.row_end)
                  report_mismatch($sformatf("row_end %b, want %b",
                                            rsp_chan.row_end, got_mean.row_end));
               if (rsp_chan.frame_end !== got_mean.frame_end)
                  report_mismatch($sformatf("frame_end %b, want %b",
                                            rsp_chan.frame_end, got_mean.frame_end));
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog on channel inactivity
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("[box_blur_3x3_stream] ERROR");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   task automatic set_idling(input int unsigned send_pct, input int unsigned hold_pct);
      send_idle_pct = send_pct;
      stall_pct     = hold_pct;
   endtask

   task automatic queue_random(input int unsigned count);
      repeat (count)
         pixel_backlog.push_back(PIX_W'($urandom_range(255)));
   endtask

   task automatic queue_same(input int unsigned count, input logic [PIX_W-1:0] pix);
      repeat (count)
         pixel_backlog.push_back(pix);
   endtask

   // Block idle: all sent, all received, pipeline drained of border pixels
   task automatic wait_quiet();
      while (pixel_backlog.size() != 0 || req_chan.valid || pending_means.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Size write; restarts the frame
   task automatic write_side(input logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      side_reg = value;
      col_pos  = 0;
      row_pos  = 0;
      @(negedge clock);
   endtask

   // Stimulus
   initial begin
      int unsigned side_pick;
      logic [CSR_W-1:0] side_val;
      for (int k = 0; k < MAX_SIZE; k++) begin
         upper_line[k]  = '0;
         middle_line[k] = '0;
      end
      for (int k = 0; k < 6; k++)
         window_pix[k] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset side length: a short run stays inside the first row, no result
      set_idling(0, 0);
      queue_random(40);
      wait_quiet();

      // Smallest frame, saturated and near-saturated means
      set_idling(0, IDLE_BOTH);
      write_side(CSR_W'(SIZE_MIN));
      queue_same(9, 8'hFF);
      queue_same(4, 8'hFF);
      queue_same(1, 8'hFE);
      queue_same(4, 8'hFF);
      wait_quiet();

      // Zero side clamps up to three; all-zero frame
      write_side('0);
      queue_same(9, 8'h00);
      wait_quiet();

      // Oversize clamps down: a short run stays inside the first row
      set_idling(IDLE_HEAVY, 0);
      write_side('1);
      queue_random(40);
      wait_quiet();

      // Random phases: mostly small sides, some clamped, some mid-frame restarts
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph % 4)
            0: set_idling(0, 0);
            1: set_idling(IDLE_HEAVY, 0);
            2: set_idling(0, IDLE_HEAVY);
            default: set_idling(IDLE_BOTH, IDLE_BOTH);
         endcase
         side_pick = $urandom_range(19);
         if (side_pick < 3)
            side_val = CSR_W'($urandom_range(SIZE_MIN - 1));
         else if (side_pick < 5)
            side_val = CSR_W'($urandom_range(40, 13));
         else
            side_val = CSR_W'($urandom_range(12, SIZE_MIN));
         // now and then carry on with the current frame
         if (ph == 0 || $urandom_range(3) != 0)
            write_side(side_val);
         queue_random($urandom_range(100, 50));
         wait_quiet();
      end

      if (error_count == 0)
         $display("[box_blur_3x3_stream] OK");
      else
         $display("[box_blur_3x3_stream] ERROR");
      $finish;
   end

endmodule
